/* rtl/rbsi_pkg.sv */
// Package for the ray/box slab intersection block.
// Holds configuration register indexes and default widths; no dependencies.
package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_ADDR_W      = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BOX_MIN_X       = 3'd0,
        REG_BOX_MIN_Y       = 3'd1,
        REG_BOX_MIN_Z       = 3'd2,
        REG_BOX_MAX_X       = 3'd3,
        REG_BOX_MAX_Y       = 3'd4,
        REG_BOX_MAX_Z       = 3'd5,
        REG_BOUNDS_VALID    = 3'd6,
        REG_COLLIDER_ACTIVE = 3'd7
    } cfg_reg_t;

endpackage

/* rtl/ray_box_slab_intersect_top.sv */
// Ray against axis-aligned box, slab method, fixed point, fully pipelined.
// Depends on rbsi_pkg for register indexes and default widths.
//
// channel | dir | beat fields (low bit first)
// s_      | in  | origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
// m_      | out | hit, entry_distance
// cfg_    | in  | write enable, register index, write data
//
// One ray per cycle while no result is held at m_; the six restoring dividers
// retire one quotient bit per stage.
// Reset clears all valid bits and loads register reset values.
// A held result at m_ stalls the whole pipeline; nothing is lost or repeated.
module ray_box_slab_intersect_top #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit, entry_distance
    output logic [((COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [rbsi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [COORD_WIDTH-1:0]             cfg_wdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int NW    = COORD_WIDTH + FRAC_BITS;
    localparam int TW    = NW + 1;
    localparam int OUT_W = ((COORD_WIDTH+7)/8)*8;

    localparam logic signed [TW-1:0] T_MAX = {1'b0, {NW{1'b1}}};
    localparam logic signed [TW-1:0] ENTRY_MAX = TW'({(CW-1){1'b1}});

    logic signed [CW-1:0] box_reg [0:5];
    logic                 bounds_valid_reg;
    logic                 active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) box_reg[i] <= '0;
            bounds_valid_reg <= 1'b0;
            active_reg       <= 1'b1;
        end else if (cfg_we) begin
            case (rbsi_pkg::cfg_reg_t'(cfg_addr))
                rbsi_pkg::REG_BOX_MIN_X:       box_reg[0] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MIN_Y:       box_reg[1] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MIN_Z:       box_reg[2] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_X:       box_reg[3] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_Y:       box_reg[4] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_Z:       box_reg[5] <= cfg_wdata;
                rbsi_pkg::REG_BOUNDS_VALID:    bounds_valid_reg <= cfg_wdata[0];
                rbsi_pkg::REG_COLLIDER_ACTIVE: active_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while the output beat waits
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Divider lanes: 0..2 use the lower bounds, 3..5 the upper bounds
    logic [CW-1:0] rem_reg [0:NW][0:5];
    logic [NW-1:0] num_reg [0:NW][0:5];
    logic [NW-1:0] q_reg   [0:NW][0:5];
    logic [CW-1:0] den_reg [0:NW][0:5];
    logic          neg_reg [0:NW][0:5];
    logic [2:0]    par_reg [0:NW];
    logic          miss_reg[0:NW];
    logic          v_reg   [0:NW];

    // Entry stage
    logic [CW-1:0] rem_next [0:5];
    logic [NW-1:0] num_next [0:5];
    logic [CW-1:0] den_next [0:5];
    logic          neg_next [0:5];
    logic [2:0]    par_next;
    logic          miss_next;

    always_comb begin
        logic signed [CW-1:0] o, d, b;
        logic signed [CW:0]   diff;
        logic [CW:0]          mag;
        logic [CW-1:0]        dmag;
        miss_next = !(active_reg && bounds_valid_reg);
        for (int l = 0; l < 6; l++) begin
            o    = s_tdata[(l%3)*CW +: CW];
            d    = s_tdata[(3+(l%3))*CW +: CW];
            b    = box_reg[l];
            diff = {b[CW-1], b} - {o[CW-1], o};
            mag  = diff[CW] ? -diff : diff;
            dmag = d[CW-1] ? -d : d;
            rem_next[l] = '0;
            num_next[l] = {mag[CW-1:0], {FRAC_BITS{1'b0}}};
            den_next[l] = dmag;
            neg_next[l] = diff[CW] ^ d[CW-1];
        end
        for (int a = 0; a < 3; a++) begin
            o = s_tdata[a*CW +: CW];
            d = s_tdata[(3+a)*CW +: CW];
            par_next[a] = (d == '0);
            if (par_next[a] && (o < box_reg[a] || o > box_reg[3+a])) miss_next = 1'b1;
        end
    end

    // Division steps: one quotient bit per stage
    logic [CW:0] trial [0:NW-1][0:5];
    logic        take  [0:NW-1][0:5];

    always_comb begin
        for (int s = 0; s < NW; s++) begin
            for (int l = 0; l < 6; l++) begin
                trial[s][l] = {rem_reg[s][l], num_reg[s][l][NW-1]};
                take[s][l]  = (trial[s][l] >= {1'b0, den_reg[s][l]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NW; s++) v_reg[s] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= s_tvalid;
            for (int s = 0; s < NW; s++) v_reg[s+1] <= v_reg[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 6; l++) begin
                rem_reg[0][l] <= rem_next[l];
                num_reg[0][l] <= num_next[l];
                q_reg[0][l]   <= '0;
                den_reg[0][l] <= den_next[l];
                neg_reg[0][l] <= neg_next[l];
            end
            par_reg[0]  <= par_next;
            miss_reg[0] <= miss_next;
            for (int s = 0; s < NW; s++) begin
                for (int l = 0; l < 6; l++) begin
                    rem_reg[s+1][l] <= take[s][l]
                        ? CW'(trial[s][l] - {1'b0, den_reg[s][l]})
                        : trial[s][l][CW-1:0];
                    num_reg[s+1][l] <= num_reg[s][l] << 1;
                    q_reg[s+1][l]   <= {q_reg[s][l][NW-2:0], take[s][l]};
                    den_reg[s+1][l] <= den_reg[s][l];
                    neg_reg[s+1][l] <= neg_reg[s][l];
                end
                par_reg[s+1]  <= par_reg[s];
                miss_reg[s+1] <= miss_reg[s];
            end
        end
    end

    // Order slab distances per axis
    logic signed [TW-1:0] tmin_reg [0:2];
    logic signed [TW-1:0] tmax_reg [0:2];
    logic                 e1_miss_reg, e1_v_reg;
    logic signed [TW-1:0] tmin_next [0:2];
    logic signed [TW-1:0] tmax_next [0:2];

    always_comb begin
        logic signed [TW-1:0] ta, tb;
        for (int a = 0; a < 3; a++) begin
            ta = neg_reg[NW][a]   ? -$signed({1'b0, q_reg[NW][a]})
                                  :  $signed({1'b0, q_reg[NW][a]});
            tb = neg_reg[NW][3+a] ? -$signed({1'b0, q_reg[NW][3+a]})
                                  :  $signed({1'b0, q_reg[NW][3+a]});
            if (par_reg[NW][a]) begin
                tmin_next[a] = '0;
                tmax_next[a] = T_MAX;
            end else if (ta > tb) begin
                tmin_next[a] = tb;
                tmax_next[a] = ta;
            end else begin
                tmin_next[a] = ta;
                tmax_next[a] = tb;
            end
        end
    end

    // Narrow the interval
    logic signed [TW-1:0] lo_reg, hi_reg;
    logic                 e2_miss_reg, e2_v_reg;
    logic signed [TW-1:0] lo_next, hi_next;

    always_comb begin
        lo_next = '0;
        hi_next = T_MAX;
        for (int a = 0; a < 3; a++) begin
            if (tmin_reg[a] > lo_next) lo_next = tmin_reg[a];
            if (tmax_reg[a] < hi_next) hi_next = tmax_reg[a];
        end
    end

    logic                 hit_next;
    logic [CW-2:0]        dist_next;
    logic                 hit_reg;
    logic [CW-2:0]        dist_reg;

    always_comb begin
        hit_next  = !e2_miss_reg && (hi_reg >= lo_reg);
        dist_next = '0;
        if (hit_next) dist_next = (lo_reg > ENTRY_MAX) ? {(CW-1){1'b1}} : lo_reg[CW-2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_v_reg      <= 1'b0;
            e2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            e1_v_reg      <= v_reg[NW];
            e2_v_reg      <= e1_v_reg;
            out_valid_reg <= e2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                tmin_reg[a] <= tmin_next[a];
                tmax_reg[a] <= tmax_next[a];
            end
            e1_miss_reg <= miss_reg[NW];
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            e2_miss_reg <= e1_miss_reg;
            hit_reg     <= hit_next;
            dist_reg    <= dist_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({dist_reg, hit_reg});

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !hit_reg |-> dist_reg == '0)
        else $error("miss with nonzero entry distance");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output held");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

/* verif/ray_box_slab_intersect_top_test.sv */
// Self-checking bench for ray_box_slab_intersect_top: directed rays, then random rays
// under several box settings, with bursty input and a stalling result side.
// Depends on rbsi_pkg and the RTL top only.

module ray_box_slab_intersect_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CW        = 32;
    localparam int          LATENCY   = 32 + 16 + 3;
    localparam int          LIMIT     = 400000;
    localparam logic [30:0] ENTRY_SAT = 31'h7fff_ffff;
    localparam int          ONE       = 32'sh0001_0000;
    localparam logic [31:0] NEG_MAX   = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
        logic               typed;
        logic               hit;
        logic [30:0]        entry;
    } ray_row_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] entry;
    } slab_hit_t;

    // origin x,y,z, direction x,y,z, typed flag, hit, entry distance
    localparam ray_row_t RAY_TABLE [16] = '{
        '{0, 0, 0, ONE, 0, 0, 1, 0, 0},
        '{-10*ONE, 0, 0, ONE, 0, 0, 1, 1, 31'h8_0000},
        '{0, 0, 0, ONE, ONE, ONE, 1, 1, 0},
        '{0, 5*ONE, 0, ONE, 0, 0, 1, 0, 0},
        '{-4*ONE, -8*ONE, 0, ONE, ONE, 0, 1, 1, 31'h6_0000},
        '{10*ONE, 0, 0, ONE, 0, 0, 1, 0, 0},
        '{10*ONE, 0, 0, -ONE, 0, 0, 1, 1, 31'h8_0000},
        '{-10*ONE, 0, 0, 1, 0, 0, 1, 1, ENTRY_SAT},
        '{0, 0, 0, 0, 0, 0, 1, 1, 0},
        '{-2*ONE, -2*ONE, -2*ONE, 0, 0, 0, 1, 1, 0},
        '{2*ONE, 2*ONE, 2*ONE + 1, 0, 0, 0, 1, 0, 0},
        '{NEG_MAX, 0, 0, POS_MAX, 0, 0, 0, 0, 0},
        '{POS_MAX, 0, 0, NEG_MAX, 0, 0, 0, 0, 0},
        '{-1, -1, -1, -1, -1, -1, 0, 0, 0},
        '{NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0},
        '{-10*ONE, 0, 0, ONE, 0, 0, 1, 0, 0}
    };

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [31:0]  m_tdata;
    logic         cfg_we = 0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    logic               box_valid;
    logic               box_active;

    slab_hit_t pending_hits [$];
    int        cycles = 0;
    int        errors = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        ready_mode = 0;

    ray_box_slab_intersect_top dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_wdata
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycles % 256 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (cycles % 8 != 0);
        endcase
    end

    always @(posedge aclk) begin
        slab_hit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result hit=%0b entry=%h", $time, m_tdata[0],
                         m_tdata[31:1]);
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (want.hit !== m_tdata[0]) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_tdata[0]);
                    errors++;
                end
                if (want.entry !== m_tdata[31:1]) begin
                    $display("%0t: entry_distance expected %h actual %h", $time, want.entry,
                             m_tdata[31:1]);
                    errors++;
                end
            end
        end
    end

    function automatic slab_hit_t slab_predict(ray_row_t r);
        longint    lo, hi, o, d, t0, t1, tmp;
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic      meets;
        slab_hit_t res;
        org = '{r.ox, r.oy, r.oz};
        dir = '{r.dx, r.dy, r.dz};
        lo = 0;
        hi = 64'h7fff_ffff_ffff_ffff;
        meets = box_active && box_valid;
        for (int a = 0; a < 3; a++) begin
            if (meets) begin
                o = longint'(org[a]);
                d = longint'(dir[a]);
                if (d == 0) begin
                    if (o < longint'(box_lo[a]) || o > longint'(box_hi[a]))
                        meets = 0;
                end else begin
                    t0 = ((longint'(box_lo[a]) - o) * 65536) / d;
                    t1 = ((longint'(box_hi[a]) - o) * 65536) / d;
                    if (t0 > t1) begin
                        tmp = t0;
                        t0 = t1;
                        t1 = tmp;
                    end
                    if (t0 > lo) lo = t0;
                    if (t1 < hi) hi = t1;
                    if (hi < lo) meets = 0;
                end
            end
        end
        res.hit = meets;
        res.entry = !meets ? 31'd0 : (lo > longint'(ENTRY_SAT)) ? ENTRY_SAT : lo[30:0];
        return res;
    endfunction

    task automatic load_box(logic [31:0] lo [3], logic [31:0] hi [3], logic valid,
                            logic active);
        logic [31:0] vals [8];
        vals = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], {31'd0, valid}, {31'd0, active}};
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= rbsi_pkg::cfg_reg_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = lo[a];
            box_hi[a] = hi[a];
        end
        box_valid = valid;
        box_active = active;
    endtask

    task automatic send_ray(ray_row_t r);
        slab_hit_t want;
        while (gap_left > 0) begin
            @(posedge aclk);
            gap_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        want = r.typed ? slab_hit_t'{r.hit, r.entry} : slab_predict(r);
        pending_hits.push_back(want);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
            gap_left = $urandom_range(1, 8);
        end
    endtask

    function automatic logic [31:0] rnd_span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [31:0] rnd_edge();
        case ($urandom_range(0, 4))
            0: return NEG_MAX;
            1: return POS_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic ray_row_t rnd_ray();
        ray_row_t r;
        logic [31:0] v [6];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++) begin
            if (kind <= 6)
                v[i] = (i < 3) ? rnd_span(-8 * ONE, 8 * ONE)
                     : ($urandom_range(0, 4) == 0) ? '0 : rnd_span(-4 * ONE, 4 * ONE);
            else if (kind == 7)
                v[i] = $urandom;
            else if (kind == 8)
                v[i] = (i < 3) ? rnd_span(-64 * ONE, 64 * ONE) : rnd_span(-255, 255);
            else
                v[i] = rnd_edge();
        end
        r = '{v[0], v[1], v[2], v[3], v[4], v[5], 1'b0, 1'b0, 31'd0};
        return r;
    endfunction

    initial begin
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [31:0] c, h;
        int phase_items;
        box_lo = '{0, 0, 0};
        box_hi = '{0, 0, 0};
        box_valid = 0;
        box_active = 1;
        burst_left = $urandom_range(1, 40);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_ray(RAY_TABLE[0]);
        load_box('{-2 * ONE, -2 * ONE, -2 * ONE}, '{2 * ONE, 2 * ONE, 2 * ONE}, 1, 1);
        for (int i = 1; i < 15; i++)
            send_ray(RAY_TABLE[i]);
        s_tvalid <= 1'b0;
        load_box('{-2 * ONE, -2 * ONE, -2 * ONE}, '{2 * ONE, 2 * ONE, 2 * ONE}, 1, 0);
        send_ray(RAY_TABLE[15]);
        s_tvalid <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            for (int a = 0; a < 3; a++) begin
                c = rnd_span(-4 * ONE, 4 * ONE);
                h = rnd_span(0, 4 * ONE);
                case (p)
                    2: begin lo[a] = NEG_MAX; hi[a] = POS_MAX; end
                    3: begin lo[a] = c + h; hi[a] = c - h; end
                    6: begin lo[a] = $urandom; hi[a] = $urandom; end
                    7: begin lo[a] = POS_MAX; hi[a] = NEG_MAX; end
                    default: begin lo[a] = c - h; hi[a] = c + h; end
                endcase
            end
            load_box(lo, hi, p != 4, p != 5);
            phase_items = (p == 4 || p == 5) ? 100 : 260;
            for (int i = 0; i < phase_items; i++)
                send_ray(rnd_ray());
            s_tvalid <= 1'b0;
        end

        while (pending_hits.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
